### hw/rtl/mpo_pkg.sv
// mpo_pkg: shared types and constants for the perturb-and-observe MPPT tracker.
// No dependencies; used by every module of the block.
package mpo_pkg;

  localparam int VOLT_W  = 16;
  localparam int CURR_W  = 16;
  localparam int POWER_W = 32;
  localparam int STEP_W  = 10;
  localparam int FRAC_W  = 16;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam int QUEUE_DEPTH = 2;

  localparam logic              MODE_RST  = 1'b1;
  localparam logic [STEP_W-1:0] STEP_RST  = 10'd50;
  localparam logic [FRAC_W-1:0] FRAC_RST  = 16'd51118;
  localparam logic [VOLT_W-1:0] FLOOR_RST = 16'd100;

  // Q0.16 rounding constant, half up
  localparam logic [VOLT_W+FRAC_W-1:0] FRAC_HALF = 32'd32768;

  localparam logic MODE_PO  = 1'b0;
  localparam logic MODE_VOC = 1'b1;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_STEP  = 2'd1,
    REG_FRAC  = 2'd2,
    REG_FLOOR = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic              mode;
    logic [STEP_W-1:0] step_mv;
    logic [FRAC_W-1:0] voc_fraction_q16;
    logic [VOLT_W-1:0] floor_mv;
  } cfg_t;

  // One classified sample between front and back
  typedef struct packed {
    logic [VOLT_W-1:0]  voltage_mv;
    logic [POWER_W-1:0] power_nw;
    logic [VOLT_W-1:0]  voc_est_mv;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### hw/rtl/mpo_front.sv
// mpo_front: input stage; accepts a sample, forms power and the fractional-VOC
// estimate, and hands the entry to the queue. Depends on mpo_pkg.
module mpo_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  logic [mpo_pkg::VOLT_W-1:0]   in_voltage_mv,
  input  logic [mpo_pkg::CURR_W-1:0]   in_current_ua,
  input  logic [mpo_pkg::FRAC_W-1:0]   voc_fraction_q16,
  input  mpo_pkg::q_stat_t             q_stat,
  output logic                         q_push,
  output mpo_pkg::entry_t              q_entry
);

  logic                                        valid_r;
  logic                                        valid_nxt;
  mpo_pkg::entry_t                             entry_r;
  mpo_pkg::entry_t                             entry_nxt;
  logic                                        take;
  logic [mpo_pkg::VOLT_W+mpo_pkg::FRAC_W-1:0]  voc_prod;

  assign full   = valid_r && q_stat.full;
  assign take   = push && !full;
  assign q_push = valid_r && !q_stat.full;
  assign q_entry = entry_r;

  always_comb begin
    voc_prod = in_voltage_mv * voc_fraction_q16 + mpo_pkg::FRAC_HALF;
    entry_nxt.voltage_mv = in_voltage_mv;
    entry_nxt.power_nw   = in_voltage_mv * in_current_ua;
    // top half of the rounded Q0.16 product; never exceeds 16 bits
    entry_nxt.voc_est_mv = voc_prod[mpo_pkg::VOLT_W+mpo_pkg::FRAC_W-1:mpo_pkg::FRAC_W];
    valid_nxt = take || (valid_r && q_stat.full);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    if (take) begin
      entry_r <= entry_nxt;
    end
  end

endmodule

### hw/rtl/mpo_queue.sv
// mpo_queue: short FIFO of classified entries between front and back.
// Depends on mpo_pkg.
module mpo_queue #(
  parameter int DEPTH = mpo_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr_en,
  input  mpo_pkg::entry_t  wr_data,
  input  logic             rd_en,
  output mpo_pkg::entry_t  rd_data,
  output mpo_pkg::q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  mpo_pkg::entry_t  mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_wr, do_rd;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_wr      = wr_en && !stat.full;
  assign do_rd      = rd_en && !stat.empty;
  assign rd_data    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (do_wr) begin
      mem[wr_ptr_r] <= wr_data;
    end
  end

endmodule

### hw/rtl/mpo_back.sv
// mpo_back: tracker state update and result register.
// Depends on mpo_pkg; fed by mpo_queue.
module mpo_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  mpo_pkg::cfg_t                 cfg,
  input  mpo_pkg::q_stat_t              q_stat,
  input  mpo_pkg::entry_t               q_entry,
  output logic                          q_pop,
  output logic                          empty,
  input  logic                          pop,
  output logic [mpo_pkg::VOLT_W-1:0]    out_target_mv,
  output logic [mpo_pkg::POWER_W-1:0]   out_power_nw,
  output logic                          out_locked
);

  localparam int EST_W = mpo_pkg::VOLT_W + 2;
  localparam int SCL_W = mpo_pkg::POWER_W + 7;

  logic                         out_valid_r, out_valid_nxt;
  logic [mpo_pkg::VOLT_W-1:0]   last_v_r, last_v_nxt;
  logic [mpo_pkg::POWER_W-1:0]  last_p_r, last_p_nxt;
  logic [mpo_pkg::VOLT_W-1:0]   est_r, est_nxt;
  logic                         conv_r, conv_nxt;
  logic [mpo_pkg::VOLT_W-1:0]   target_r;
  logic [mpo_pkg::POWER_W-1:0]  power_r;

  logic                         take;
  logic                         up_v, up_p;
  logic signed [EST_W-1:0]      est_s, step_s;
  logic [mpo_pkg::POWER_W-1:0]  diff;
  logic [SCL_W-1:0]             diff_x100;
  logic [mpo_pkg::VOLT_W-1:0]   est_sat;

  assign take          = !q_stat.empty && (!out_valid_r || pop);
  assign q_pop         = take;
  assign empty         = !out_valid_r;
  assign out_target_mv = target_r;
  assign out_power_nw  = power_r;
  assign out_locked    = conv_r;

  always_comb begin
    up_v   = q_entry.voltage_mv > last_v_r;
    up_p   = q_entry.power_nw > last_p_r;
    step_s = $signed({{(EST_W-mpo_pkg::STEP_W){1'b0}}, cfg.step_mv});
    diff   = up_p ? (q_entry.power_nw - last_p_r) : (last_p_r - q_entry.power_nw);
    // 100*d as 64d + 32d + 4d
    diff_x100 = ({7'd0, diff} << 6) + ({7'd0, diff} << 5) + ({7'd0, diff} << 2);

    last_v_nxt = last_v_r;
    last_p_nxt = last_p_r;
    conv_nxt   = conv_r;

    if (cfg.mode == mpo_pkg::MODE_PO) begin
      if (last_v_r != '0) begin
        est_s = $signed({2'b00, est_r}) + ((up_v == up_p) ? step_s : -step_s);
      end else begin
        // seed from the measured voltage
        est_s = $signed({2'b00, q_entry.voltage_mv});
      end
      if (diff_x100 <= {7'd0, last_p_r}) begin
        conv_nxt = 1'b1;
      end
      last_v_nxt = q_entry.voltage_mv;
      last_p_nxt = q_entry.power_nw;
    end else begin
      est_s    = $signed({2'b00, q_entry.voc_est_mv});
      conv_nxt = 1'b1;
    end

    if (est_s < 0) begin
      est_sat = '0;
    end else if (est_s > $signed(EST_W'(16'hFFFF))) begin
      est_sat = '1;
    end else begin
      est_sat = est_s[mpo_pkg::VOLT_W-1:0];
    end
    est_nxt = (est_sat < cfg.floor_mv) ? cfg.floor_mv : est_sat;

    out_valid_nxt = take || (out_valid_r && !pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      last_v_r    <= '0;
      last_p_r    <= '0;
      est_r       <= '0;
      conv_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (take) begin
        last_v_r <= last_v_nxt;
        last_p_r <= last_p_nxt;
        est_r    <= est_nxt;
        conv_r   <= conv_nxt;
      end
    end
    if (take) begin
      target_r <= est_nxt;
      power_r  <= q_entry.power_nw;
    end
  end

endmodule

### hw/rtl/mppt_perturb_observe_tracker.sv
// mppt_perturb_observe_tracker: top level of the MPPT tracker; register file,
// front stage, entry queue and back stage. Depends on mpo_pkg and its submodules.
//
//  channel   direction  handshake            beat contents
//  -------   ---------  -------------------  ---------------------------------
//  input     in         push / full          in_voltage_mv, in_current_ua
//  result    out        empty / pop          out_target_mv, out_power_nw, out_locked
//  config    in/out     psel/penable/pready  paddr, pwdata, prdata (4 regs at 4*i)
//
// One beat in and one beat out per cycle sustained while results are popped; a result
// passes through the front register, the queue and then the result register before
// it shows on the ports; a full queue or a held-back pop can stall it between them.
// The front holds the 16x16 power and VOC multiplies; the back holds the
// state update, so the state loop sets the one-beat-per-cycle figure.
// Reset (rst_n low, synchronous) clears tracker state, queue and the registers
// to their defaults. A stalled result waits in the result register while the
// queue keeps taking input beats; full rises only when front and queue are full.
module mppt_perturb_observe_tracker #(
  parameter int QUEUE_DEPTH = mpo_pkg::QUEUE_DEPTH
) (
  input  logic                         clk,
  input  logic                         rst_n,
  // input channel
  input  logic                         push,
  output logic                         full,
  input  logic [mpo_pkg::VOLT_W-1:0]   in_voltage_mv,
  input  logic [mpo_pkg::CURR_W-1:0]   in_current_ua,
  // result channel
  output logic                         empty,
  input  logic                         pop,
  output logic [mpo_pkg::VOLT_W-1:0]   out_target_mv,
  output logic [mpo_pkg::POWER_W-1:0]  out_power_nw,
  output logic                         out_locked,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [mpo_pkg::ADDR_W-1:0]   paddr,
  input  logic [mpo_pkg::DATA_W-1:0]   pwdata,
  output logic [mpo_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);

  mpo_pkg::cfg_t     cfg_r, cfg_nxt;
  mpo_pkg::reg_idx_t reg_idx;
  logic              wr_en;

  mpo_pkg::q_stat_t  q_stat;
  mpo_pkg::entry_t   fq_entry, qb_entry;
  logic              q_push, q_pop;

  // ---------------- register file ----------------
  assign pready  = 1'b1;
  assign reg_idx = mpo_pkg::reg_idx_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    prdata  = '0;
    case (reg_idx)
      mpo_pkg::REG_MODE: begin
        prdata = {{(mpo_pkg::DATA_W-1){1'b0}}, cfg_r.mode};
        if (wr_en) cfg_nxt.mode = pwdata[0];
      end
      mpo_pkg::REG_STEP: begin
        prdata = {{(mpo_pkg::DATA_W-mpo_pkg::STEP_W){1'b0}}, cfg_r.step_mv};
        if (wr_en) cfg_nxt.step_mv = pwdata[mpo_pkg::STEP_W-1:0];
      end
      mpo_pkg::REG_FRAC: begin
        prdata = {{(mpo_pkg::DATA_W-mpo_pkg::FRAC_W){1'b0}}, cfg_r.voc_fraction_q16};
        if (wr_en) cfg_nxt.voc_fraction_q16 = pwdata[mpo_pkg::FRAC_W-1:0];
      end
      mpo_pkg::REG_FLOOR: begin
        prdata = {{(mpo_pkg::DATA_W-mpo_pkg::VOLT_W){1'b0}}, cfg_r.floor_mv};
        if (wr_en) cfg_nxt.floor_mv = pwdata[mpo_pkg::VOLT_W-1:0];
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode             <= mpo_pkg::MODE_RST;
      cfg_r.step_mv          <= mpo_pkg::STEP_RST;
      cfg_r.voc_fraction_q16 <= mpo_pkg::FRAC_RST;
      cfg_r.floor_mv         <= mpo_pkg::FLOOR_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // ---------------- front: accept and multiply ----------------
  mpo_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_voltage_mv    (in_voltage_mv),
    .in_current_ua    (in_current_ua),
    .voc_fraction_q16 (cfg_r.voc_fraction_q16),
    .q_stat           (q_stat),
    .q_push           (q_push),
    .q_entry          (fq_entry)
  );

  // ---------------- decoupling queue ----------------
  mpo_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (fq_entry),
    .rd_en   (q_pop),
    .rd_data (qb_entry),
    .stat    (q_stat)
  );

  // ---------------- back: tracker update and result ----------------
  mpo_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .q_stat        (q_stat),
    .q_entry       (qb_entry),
    .q_pop         (q_pop),
    .empty         (empty),
    .pop           (pop),
    .out_target_mv (out_target_mv),
    .out_power_nw  (out_power_nw),
    .out_locked    (out_locked)
  );

endmodule

### hw/rtl/mpo_checker.sv
// mpo_checker: port-level assertions for the MPPT tracker, bound to the top.
// Depends on mpo_pkg and mppt_perturb_observe_tracker.
module mpo_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         push,
  input logic                         full,
  input logic                         empty,
  input logic                         pop,
  input logic [mpo_pkg::VOLT_W-1:0]   out_target_mv,
  input logic [mpo_pkg::POWER_W-1:0]  out_power_nw,
  input logic                         out_locked,
  input logic                         psel,
  input logic                         penable,
  input logic                         pwrite,
  input logic [mpo_pkg::ADDR_W-1:0]   paddr,
  input logic [mpo_pkg::DATA_W-1:0]   pwdata,
  input logic                         pready
);

  logic [3:0]                 pend_r, pend_nxt;
  logic                       seen_lock_r;
  logic [mpo_pkg::VOLT_W-1:0] floor_r;
  logic                       in_beat, out_beat, cfg_wr;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;
  assign cfg_wr   = psel && penable && pwrite && pready;

  always_comb begin
    pend_nxt = pend_r;
    if (in_beat && !out_beat) begin
      pend_nxt = pend_r + 4'd1;
    end else if (out_beat && !in_beat) begin
      pend_nxt = pend_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= '0;
      seen_lock_r <= 1'b0;
      floor_r     <= mpo_pkg::FLOOR_RST;
    end else begin
      pend_r <= pend_nxt;
      if (out_beat && out_locked) begin
        seen_lock_r <= 1'b1;
      end
      if (cfg_wr && (mpo_pkg::reg_idx_t'(paddr[3:2]) == mpo_pkg::REG_FLOOR)) begin
        floor_r <= pwdata[mpo_pkg::VOLT_W-1:0];
      end
    end
  end

  // no result appears without an outstanding input beat
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_r == 4'd0) |-> empty)
    else $error("result shown with no input beat outstanding");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_power_nw) && $stable(out_target_mv)))
    else $error("stalled result changed");

  // locked is sticky until reset
  a_lock_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && seen_lock_r) |-> out_locked)
    else $error("locked flag dropped");

  // the estimate never sits below the floor
  a_floor: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_target_mv >= floor_r))
    else $error("target below floor");

endmodule

bind mppt_perturb_observe_tracker mpo_checker u_mpo_checker (.*);
